>>> sv/cbpe_pkg.sv
// Shared constants and types for the cubic Bezier point evaluator.
package cbpe_pkg;

	localparam int COORD_W        = 10;
	localparam int NUM_CTRL_PTS   = 4;
	localparam int DEF_FRAC_BITS  = 16;
	localparam int APB_DATA_W     = 32;
	localparam int APB_ADDR_W     = 5;
	localparam int REG_IDX_W      = 3;
	localparam int PT_IDX_W       = 2;
	localparam int COEF_W         = COORD_W + 2;
	localparam int OUT_TDATA_W    = ((2 * COORD_W + 7) / 8) * 8;

	typedef logic [COORD_W-1:0] coord_t;
	typedef coord_t             point_arr_t [NUM_CTRL_PTS];

	// Register file layout: even index is x, odd index is y of point index/2.
	localparam logic AXIS_X = 1'b0;
	localparam logic AXIS_Y = 1'b1;

	localparam point_arr_t PX_RESET = '{10'd200, 10'd400, 10'd300, 10'd500};
	localparam point_arr_t PY_RESET = '{10'd200, 10'd200, 10'd400, 10'd400};

	// Three times a coordinate, as used by the two middle Bernstein terms.
	function automatic logic [COEF_W-1:0] triple(input coord_t c);
		triple = {2'b00, c} + {1'b0, c, 1'b0};
	endfunction

endpackage

>>> sv/cubic_bezier_point_eval.sv
// Cubic Bezier point evaluator: pipelined Bernstein-form blend with an APB register port.
//
// Each stream transfer on the slave side carries one curve parameter t, an unsigned fraction
// with PARAM_FRAC_BITS fraction bits (1 << PARAM_FRAC_BITS means t = 1; larger codes in the
// low PARAM_FRAC_BITS+1 bits are treated as t = 1, higher bits are ignored). The block answers
// with exactly one transfer on the master side holding the floored x and y of the cubic Bezier
// point B(t) for the four control points held in the eight APB registers (point0_x at byte
// 0x00, point0_y at 0x04, through point3_y at 0x1C, ten bits each, reset to the points (200,200)
// (400,200) (300,400) (500,400)). The datapath is a six-stage pipeline: saturate and form
// u = 1 - t, squares, cubes (the Bernstein weights), coefficient products, pair sums, and the
// final sum with the 3*PARAM_FRAC_BITS shift. It accepts one parameter every clock cycle while
// the output side is not stalled; each result is held in the stage-6 register and presented on
// the master side until it is taken. Each stage holds its item while the stage after it is
// full and stalled, so bubbles are squeezed out and nothing is lost or repeated under
// back-pressure. Control points are sampled by the product stage, so registers should only be
// rewritten while no parameter is in flight.
module cubic_bezier_point_eval #(
	parameter int PARAM_FRAC_BITS = cbpe_pkg::DEF_FRAC_BITS
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// Parameter stream.
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	input  logic [((PARAM_FRAC_BITS+8)/8)*8-1:0]   s_tdata,  // [PARAM_FRAC_BITS:0] param_t
	// Curve point stream.
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	output logic [cbpe_pkg::OUT_TDATA_W-1:0]       m_tdata,  // [9:0] curve_x, [19:10] curve_y
	// Register port.
	input  logic                                   psel,
	input  logic                                   penable,
	input  logic                                   pwrite,
	input  logic [cbpe_pkg::APB_ADDR_W-1:0]        paddr,
	input  logic [cbpe_pkg::APB_DATA_W-1:0]        pwdata,
	output logic [cbpe_pkg::APB_DATA_W-1:0]        prdata,
	output logic                                   pready
);
	import cbpe_pkg::*;

	localparam int F   = PARAM_FRAC_BITS;
	localparam int TW  = F + 1;           // t and u, 0..ONE
	localparam int SQW = 2 * F + 1;       // squares and t*u, 0..ONE^2
	localparam int WW  = 3 * F + 1;       // Bernstein weights, 0..ONE^3
	localparam int SW  = 3 * F + COORD_W; // weighted sums, below 2^COORD_W * ONE^3
	localparam int PW  = WW + COEF_W;     // raw product width before trimming

	localparam logic [TW-1:0] ONE = {1'b1, {F{1'b0}}};

	// ------------------------------------------------------------------
	// Control-point registers and APB access.
	// ------------------------------------------------------------------
	coord_t px_q [NUM_CTRL_PTS];
	coord_t py_q [NUM_CTRL_PTS];

	logic                  cfg_wr;
	logic [REG_IDX_W-1:0]  reg_idx;
	logic [PT_IDX_W-1:0]   pt_idx;
	logic                  axis;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign reg_idx = paddr[REG_IDX_W+1:2];
	assign pt_idx  = reg_idx[REG_IDX_W-1:1];
	assign axis    = reg_idx[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			px_q <= PX_RESET;
			py_q <= PY_RESET;
		end else if (cfg_wr) begin
			unique case (axis)
				AXIS_X: px_q[pt_idx] <= pwdata[COORD_W-1:0];
				AXIS_Y: py_q[pt_idx] <= pwdata[COORD_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (axis)
			AXIS_X: prdata[COORD_W-1:0] = px_q[pt_idx];
			AXIS_Y: prdata[COORD_W-1:0] = py_q[pt_idx];
			default: prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Stage enables: a stage loads when it is empty or its successor loads.
	// ------------------------------------------------------------------
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic en1, en2, en3, en4, en5, en6;

	assign en6      = ~v_s6 | m_tready;
	assign en5      = ~v_s5 | en6;
	assign en4      = ~v_s4 | en5;
	assign en3      = ~v_s3 | en4;
	assign en2      = ~v_s2 | en3;
	assign en1      = ~v_s1 | en2;
	assign s_tready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en1) v_s1 <= s_tvalid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: clamp t to one and form u = 1 - t.
	// ------------------------------------------------------------------
	logic [TW-1:0] t_in, t_sat;
	logic [TW-1:0] t_s1, u_s1;

	assign t_in  = s_tdata[TW-1:0];
	assign t_sat = (t_in > ONE) ? ONE : t_in;

	always_ff @(posedge clk) begin
		if (en1) begin
			t_s1 <= t_sat;
			u_s1 <= ONE - t_sat;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: t^2, t*u, u^2.
	// ------------------------------------------------------------------
	logic [2*TW-1:0] tt_full, tu_full, uu_full;
	logic [SQW-1:0]  tt_s2, tu_s2, uu_s2;
	logic [TW-1:0]   t_s2, u_s2;

	assign tt_full = t_s1 * t_s1;
	assign tu_full = t_s1 * u_s1;
	assign uu_full = u_s1 * u_s1;

	always_ff @(posedge clk) begin
		if (en2) begin
			tt_s2 <= tt_full[SQW-1:0];
			tu_s2 <= tu_full[SQW-1:0];
			uu_s2 <= uu_full[SQW-1:0];
			t_s2  <= t_s1;
			u_s2  <= u_s1;
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: cubes u^3, t*u^2, t^2*u, t^3. The factor three of the middle
	// terms is folded into the coefficients in stage 4.
	// ------------------------------------------------------------------
	logic [SQW+TW-1:0] w0_full, w1_full, w2_full, w3_full;
	logic [WW-1:0]     w0_s3, w1_s3, w2_s3, w3_s3;

	assign w0_full = uu_s2 * u_s2;
	assign w1_full = tu_s2 * u_s2;
	assign w2_full = tu_s2 * t_s2;
	assign w3_full = tt_s2 * t_s2;

	always_ff @(posedge clk) begin
		if (en3) begin
			w0_s3 <= w0_full[WW-1:0];
			w1_s3 <= w1_full[WW-1:0];
			w2_s3 <= w2_full[WW-1:0];
			w3_s3 <= w3_full[WW-1:0];
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: coefficient products for both axes.
	// ------------------------------------------------------------------
	logic [COEF_W-1:0] cx0, cx1, cx2, cx3, cy0, cy1, cy2, cy3;
	logic [PW-1:0]     px0_full, px1_full, px2_full, px3_full;
	logic [PW-1:0]     py0_full, py1_full, py2_full, py3_full;
	logic [SW-1:0]     px0_s4, px1_s4, px2_s4, px3_s4;
	logic [SW-1:0]     py0_s4, py1_s4, py2_s4, py3_s4;

	assign cx0 = {2'b00, px_q[0]};
	assign cx1 = triple(px_q[1]);
	assign cx2 = triple(px_q[2]);
	assign cx3 = {2'b00, px_q[3]};
	assign cy0 = {2'b00, py_q[0]};
	assign cy1 = triple(py_q[1]);
	assign cy2 = triple(py_q[2]);
	assign cy3 = {2'b00, py_q[3]};

	assign px0_full = cx0 * w0_s3;
	assign px1_full = cx1 * w1_s3;
	assign px2_full = cx2 * w2_s3;
	assign px3_full = cx3 * w3_s3;
	assign py0_full = cy0 * w0_s3;
	assign py1_full = cy1 * w1_s3;
	assign py2_full = cy2 * w2_s3;
	assign py3_full = cy3 * w3_s3;

	always_ff @(posedge clk) begin
		if (en4) begin
			px0_s4 <= px0_full[SW-1:0];
			px1_s4 <= px1_full[SW-1:0];
			px2_s4 <= px2_full[SW-1:0];
			px3_s4 <= px3_full[SW-1:0];
			py0_s4 <= py0_full[SW-1:0];
			py1_s4 <= py1_full[SW-1:0];
			py2_s4 <= py2_full[SW-1:0];
			py3_s4 <= py3_full[SW-1:0];
		end
	end

	// ------------------------------------------------------------------
	// Stage 5: pair sums. Every partial and total sum stays below
	// 2^COORD_W * ONE^3, so SW bits never overflow.
	// ------------------------------------------------------------------
	logic [SW-1:0] sx01_s5, sx23_s5, sy01_s5, sy23_s5;

	always_ff @(posedge clk) begin
		if (en5) begin
			sx01_s5 <= px0_s4 + px1_s4;
			sx23_s5 <= px2_s4 + px3_s4;
			sy01_s5 <= py0_s4 + py1_s4;
			sy23_s5 <= py2_s4 + py3_s4;
		end
	end

	// ------------------------------------------------------------------
	// Stage 6: final sum, floored by dropping the 3F fraction bits.
	// ------------------------------------------------------------------
	logic [SW-1:0] sum_x, sum_y;
	coord_t        x_s6, y_s6;

	assign sum_x = sx01_s5 + sx23_s5;
	assign sum_y = sy01_s5 + sy23_s5;

	always_ff @(posedge clk) begin
		if (en6) begin
			x_s6 <= sum_x[SW-1:3*F];
			y_s6 <= sum_y[SW-1:3*F];
		end
	end

	assign m_tvalid = v_s6;
	assign m_tdata  = {{(OUT_TDATA_W-2*COORD_W){1'b0}}, y_s6, x_s6};

	// ------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------
	logic [WW+1:0] w_total;
	assign w_total = {2'b00, w0_s3} + {1'b0, w1_s3, 1'b0} + {2'b00, w1_s3}
		+ {1'b0, w2_s3, 1'b0} + {2'b00, w2_s3} + {2'b00, w3_s3};

	// The input side may only stall when a finished result is waiting.
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled while the output stage was empty");

	// The Bernstein weights of every item sum to exactly one cubed.
	a_weight_sum: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> (w_total == ({{(WW+1){1'b0}}, 1'b1} << (3 * F))))
		else $error("Bernstein weights do not sum to one");

	// The clamped parameter never exceeds one and t + u is one.
	a_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> (t_s1 <= ONE) && ((t_s1 + u_s1) == ONE))
		else $error("parameter clamp or complement is wrong");

	// An item in the pair-sum stage that moves on reaches the output.
	a_handoff: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s5 && en6) |=> m_tvalid)
		else $error("item lost between the last two stages");

endmodule
